// ----- rtl/rgbsat_pkg.sv -----
`default_nettype none
package rgbsat_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 8;
    localparam int CFG_W   = 9;
    localparam int ENT_W   = 32;    // table entry and row sum width (mod 2^32)
    localparam int AREA_W  = 17;    // up to 256*256
    localparam int AQ_W    = ENT_W + AREA_W;
    localparam int SS_W    = 2 * ENT_W;
    localparam int SCORE_W = 32;
    localparam int NCH     = 3;
    localparam int WORD_W  = 2 * NCH * ENT_W;   // {sq_b,sq_g,sq_r,s_b,s_g,s_r}
    localparam int IN_W    = 7 * 8;
    localparam int OUT_W   = 7 * 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_IMG_WIDTH  = 1'b0;
    localparam logic CFG_IMG_HEIGHT = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LDWR  = 8'b0000_0010,
        ST_QRD   = 8'b0000_0100,
        ST_QACC  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_DIVGO = 8'b0010_0000,
        ST_DIVW  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/rgbsat_mem.sv -----
`default_nettype none
// Simple dual-port table RAM with a registered read.
module rgbsat_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire                              i_clk,
    input  wire                              i_we,
    input  wire  [AW-1:0]                    i_waddr,
    input  wire  [rgbsat_pkg::WORD_W-1:0]    i_wdata,
    input  wire  [AW-1:0]                    i_raddr,
    output logic [rgbsat_pkg::WORD_W-1:0]    o_rdata
);
    logic [rgbsat_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [rgbsat_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- rtl/rgbsat_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, producing an N-bit quotient.
module rgbsat_div #(
    parameter int N = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire  [N-1:0]                      i_dividend,
    input  wire  [rgbsat_pkg::AREA_W-1:0]     i_divisor,
    output logic                              o_done,
    output logic [N-1:0]                      o_quotient
);
    localparam int DV = rgbsat_pkg::AREA_W;
    localparam int CW = $clog2(N);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_quo;
    logic [DV-1:0] r_rem;
    logic [DV-1:0] r_div;
    logic [DV:0]   rem_sh;
    logic [DV:0]   trial;

    always_comb begin
        rem_sh = {r_rem, r_quo[N-1]};
        trial  = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!trial[DV]) begin
                    r_rem <= trial[DV-1:0];
                    r_quo <= {r_quo[N-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[DV-1:0];
                    r_quo <= {r_quo[N-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ----- rtl/rgb_integral_image_region_stats.sv -----
`default_nettype none
// Summed-area tables of an RGB image with rectangle statistics.
// Load beats (tuser = 0) carry pixels in raster order; each pixel updates six
// tables (per-channel sum and sum of squares) held in one wide synchronous RAM.
// A load reads the entry above into the RAM's read register, then writes the new
// entry (read-modify-write through the single RAM port pair).
// Query beats (tuser = 1) name a rectangle by inclusive corners. Four corner
// reads (one per cycle) build each channel's sum S and square sum Q, then per
// channel a multiply step and a bit-serial divide run; the serial divider sets
// how long a query takes.
// Result: truncated channel means and score = sum over channels of
// (area*Q - S*S)/area. Rejected queries (corners out of order, outside the
// image, or no complete image yet) return bad_rect = 1 with all data zero.
// A configuration write restarts loading; the table RAM is not cleared.
module rgb_integral_image_region_stats #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [31:24] ul_x,
    // [39:32] ul_y, [47:40] lr_x, [55:48] lr_y
    input  wire  [rgbsat_pkg::IN_W-1:0]      s_axis_tdata,
    // [0] operation
    input  wire                              s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [7:0] avg_red, [15:8] avg_green, [23:16] avg_blue, [55:24] variance_score
    output logic [rgbsat_pkg::OUT_W-1:0]     m_axis_tdata,
    // [0] bad_rect
    output logic                             m_axis_tuser,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_index,
    input  wire  [rgbsat_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(DEPTH);
    localparam int EW = rgbsat_pkg::ENT_W;
    localparam int PW = rgbsat_pkg::PIX_W;
    localparam int NC = rgbsat_pkg::NCH;
    localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);

    rgbsat_pkg::t_state r_state;

    // configuration and load position
    logic [rgbsat_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_done_img;
    logic [EW-1:0] r_rs  [NC];
    logic [EW-1:0] r_rsq [NC];

    // load write-back stage
    logic [AW-1:0] r_ld_addr;
    logic          r_ld_row0;
    logic [EW-1:0] r_ld_s  [NC];
    logic [EW-1:0] r_ld_q  [NC];

    // query
    logic [rgbsat_pkg::COORD_W-1:0] r_ux, r_uy, r_lx, r_ly;
    logic [1:0]    r_k;
    logic          r_pend, r_pend_neg, r_pend_zero;
    logic [EW-1:0] r_acc [2*NC];
    logic [rgbsat_pkg::AREA_W-1:0] r_area;
    logic [1:0]    r_ch;
    logic [rgbsat_pkg::AQ_W-1:0] r_aq;
    logic [rgbsat_pkg::SS_W-1:0] r_ss;
    logic [rgbsat_pkg::SCORE_W-1:0] r_score;
    logic [PW-1:0] r_avg [NC];
    logic          r_bad;

    // output register
    logic                         r_out_valid;
    logic [rgbsat_pkg::OUT_W-1:0] r_out_data;
    logic                         r_out_bad;

    // RAM
    logic                          mem_we;
    logic [AW-1:0]                 mem_raddr;
    logic [rgbsat_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

    // dividers
    logic                          div_start;
    logic [rgbsat_pkg::SS_W-1:0]   div_diff;
    logic                          dq_done, ds_done;
    logic [rgbsat_pkg::SS_W-1:0]   dq_quo;
    logic [rgbsat_pkg::SS_W-1:0]   ds_quo;

    logic          in_fire, ld_fire, q_fire;
    logic [PW-1:0] pix [NC];
    logic [EW-1:0] ns_s [NC];
    logic [EW-1:0] ns_q [NC];
    logic          col_wrap, row_wrap;
    logic [AW-1:0] addr_cur, addr_above, addr_corner;
    logic [rgbsat_pkg::COORD_W-1:0] cx, cy;
    logic          q_bad;
    logic [EW-1:0] s_sel, q_sel;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = XW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = YW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = YW'(MAX_HEIGHT);
        end else begin
            h_eff = YW'(r_cfg_h);
        end
    end

    assign s_axis_tready = (r_state == rgbsat_pkg::ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign ld_fire = in_fire && (s_axis_tuser == rgbsat_pkg::OP_LOAD);
    assign q_fire  = in_fire && (s_axis_tuser == rgbsat_pkg::OP_QUERY);

    always_comb begin
        pix[0] = s_axis_tdata[7:0];
        pix[1] = s_axis_tdata[15:8];
        pix[2] = s_axis_tdata[23:16];
        for (int c = 0; c < NC; c++) begin
            ns_s[c] = r_rs[c] + EW'(pix[c]);
            ns_q[c] = r_rsq[c] + EW'(16'(pix[c]) * 16'(pix[c]));
        end
        col_wrap = (32'(r_col) + 1) >= 32'(w_eff);
        row_wrap = (32'(r_row) + 1) >= 32'(h_eff);
        addr_cur   = AW'(r_row) * MW_A + AW'(r_col);
        addr_above = AW'(r_row - 1'b1) * MW_A + AW'(r_col);
        // corner k: bit0 picks left edge (ux-1), bit1 picks top edge (uy-1)
        cx = r_k[0] ? (r_ux - 1'b1) : r_lx;
        cy = r_k[1] ? (r_uy - 1'b1) : r_ly;
        addr_corner = AW'(cy) * MW_A + AW'(cx);
        mem_raddr = (r_state == rgbsat_pkg::ST_QRD) ? addr_corner : addr_above;
        q_bad = !r_done_img
             || (s_axis_tdata[31:24] > s_axis_tdata[47:40])
             || (s_axis_tdata[39:32] > s_axis_tdata[55:48])
             || (32'(s_axis_tdata[47:40]) >= 32'(w_eff))
             || (32'(s_axis_tdata[55:48]) >= 32'(h_eff));
    end

    // write-back of a load: row sum plus entry above
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            mem_wdata[c*EW +: EW] = r_ld_s[c]
                + (r_ld_row0 ? '0 : mem_rdata[c*EW +: EW]);
            mem_wdata[(NC+c)*EW +: EW] = r_ld_q[c]
                + (r_ld_row0 ? '0 : mem_rdata[(NC+c)*EW +: EW]);
        end
        mem_we = (r_state == rgbsat_pkg::ST_LDWR);
    end

    always_comb begin
        case (r_ch)
            2'd1:    begin s_sel = r_acc[1]; q_sel = r_acc[4]; end
            2'd2:    begin s_sel = r_acc[2]; q_sel = r_acc[5]; end
            default: begin s_sel = r_acc[0]; q_sel = r_acc[3]; end
        endcase
        div_start = (r_state == rgbsat_pkg::ST_DIVGO);
        div_diff  = (rgbsat_pkg::SS_W'(r_aq) >= r_ss)
                  ? (rgbsat_pkg::SS_W'(r_aq) - r_ss) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rgbsat_pkg::ST_IDLE;
            r_cfg_w     <= rgbsat_pkg::CFG_W'(256);
            r_cfg_h     <= rgbsat_pkg::CFG_W'(256);
            r_col       <= '0;
            r_row       <= '0;
            r_done_img  <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NC; c++) begin
                r_rs[c]  <= '0;
                r_rsq[c] <= '0;
            end
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // corner data arrives in the cycle after its read
            if (r_pend) begin
                for (int j = 0; j < 2*NC; j++) begin
                    if (!r_pend_zero) begin
                        r_acc[j] <= r_pend_neg ? (r_acc[j] - mem_rdata[j*EW +: EW])
                                               : (r_acc[j] + mem_rdata[j*EW +: EW]);
                    end
                end
            end

            unique case (r_state)
                rgbsat_pkg::ST_IDLE: begin
                    if (ld_fire) begin
                        r_ld_addr <= addr_cur;
                        r_ld_row0 <= (r_row == '0);
                        for (int c = 0; c < NC; c++) begin
                            r_ld_s[c] <= ns_s[c];
                            r_ld_q[c] <= ns_q[c];
                            r_rs[c]   <= col_wrap ? '0 : ns_s[c];
                            r_rsq[c]  <= col_wrap ? '0 : ns_q[c];
                        end
                        if (r_col == '0 && r_row == '0) begin
                            r_done_img <= 1'b0;
                        end
                        if (col_wrap) begin
                            r_col <= '0;
                            if (row_wrap) begin
                                r_row      <= '0;
                                r_done_img <= 1'b1;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= rgbsat_pkg::ST_LDWR;
                    end else if (q_fire) begin
                        r_ux    <= s_axis_tdata[31:24];
                        r_uy    <= s_axis_tdata[39:32];
                        r_lx    <= s_axis_tdata[47:40];
                        r_ly    <= s_axis_tdata[55:48];
                        r_bad   <= q_bad;
                        r_k     <= '0;
                        r_ch    <= '0;
                        r_score <= '0;
                        for (int j = 0; j < 2*NC; j++) begin
                            r_acc[j] <= '0;
                        end
                        r_state <= q_bad ? rgbsat_pkg::ST_OUT : rgbsat_pkg::ST_QRD;
                    end
                end
                rgbsat_pkg::ST_LDWR: begin
                    r_state <= rgbsat_pkg::ST_IDLE;
                end
                rgbsat_pkg::ST_QRD: begin
                    r_pend      <= 1'b1;
                    r_pend_neg  <= r_k[0] ^ r_k[1];
                    r_pend_zero <= (r_k[0] && r_ux == '0) || (r_k[1] && r_uy == '0);
                    r_k         <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_state <= rgbsat_pkg::ST_QACC;
                    end
                end
                rgbsat_pkg::ST_QACC: begin
                    r_pend  <= 1'b0;
                    r_area  <= rgbsat_pkg::AREA_W'(9'(r_lx) - 9'(r_ux) + 9'd1)
                             * rgbsat_pkg::AREA_W'(9'(r_ly) - 9'(r_uy) + 9'd1);
                    r_state <= rgbsat_pkg::ST_MUL;
                end
                rgbsat_pkg::ST_MUL: begin
                    r_aq    <= r_area * q_sel;
                    r_ss    <= s_sel * s_sel;
                    r_state <= rgbsat_pkg::ST_DIVGO;
                end
                rgbsat_pkg::ST_DIVGO: begin
                    r_state <= rgbsat_pkg::ST_DIVW;
                end
                rgbsat_pkg::ST_DIVW: begin
                    if (dq_done && ds_done) begin
                        r_score    <= r_score + dq_quo[rgbsat_pkg::SCORE_W-1:0];
                        r_avg[r_ch] <= ds_quo[PW-1:0];
                        if (r_ch == 2'd2) begin
                            r_state <= rgbsat_pkg::ST_OUT;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= rgbsat_pkg::ST_MUL;
                        end
                    end
                end
                rgbsat_pkg::ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_bad   <= r_bad;
                        r_out_data  <= r_bad ? '0
                                     : {r_score, r_avg[2], r_avg[1], r_avg[0]};
                        r_state     <= rgbsat_pkg::ST_IDLE;
                    end
                end
                default: r_state <= rgbsat_pkg::ST_IDLE;
            endcase

            // config write restarts loading
            if (i_cfg_we) begin
                if (i_cfg_index == rgbsat_pkg::CFG_IMG_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                end else begin
                    r_cfg_h <= i_cfg_data;
                end
                r_col      <= '0;
                r_row      <= '0;
                r_done_img <= 1'b0;
                for (int c = 0; c < NC; c++) begin
                    r_rs[c]  <= '0;
                    r_rsq[c] <= '0;
                end
            end
        end
    end

    rgbsat_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_ld_addr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // score quotient: (area*Q - S*S) / area
    rgbsat_div #(.N(rgbsat_pkg::SS_W)) u_div_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_diff),
        .i_divisor  (r_area),
        .o_done     (dq_done),
        .o_quotient (dq_quo)
    );

    // mean quotient: S / area, same length so both finish together
    rgbsat_div #(.N(rgbsat_pkg::SS_W)) u_div_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rgbsat_pkg::SS_W'(s_sel)),
        .i_divisor  (r_area),
        .o_done     (ds_done),
        .o_quotient (ds_quo)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_bad;
endmodule
`default_nettype wire

// ----- rtl/rgbsat_checker.sv -----
`default_nettype none
module rgbsat_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire                          s_axis_tuser,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [rgbsat_pkg::OUT_W-1:0]  m_axis_tdata,
    input wire                          m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("rejected query carries nonzero data");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat after reset");

    a_load_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == rgbsat_pkg::OP_LOAD
        |=> !s_axis_tready)
        else $error("load write-back cycle not taken");
endmodule

bind rgb_integral_image_region_stats rgbsat_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
